// File: rtl/core/tfg_pkg.sv
`timescale 1ns / 1ps

package tfg_pkg;

    localparam int NUM_STREAMS_DEF = 4;
    localparam int STREAM_IDX_W    = 4;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_AGE    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FUTURE = CFG_INDEX_W'(1);

    // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2**63
    localparam logic [63:0] RECIP_1000  = 64'd9444732965739290428;
    localparam int          RECIP_SHIFT = 73;
    localparam int          Q_LSB       = RECIP_SHIFT - 64;
    localparam int          Q_W         = 54;

    typedef enum logic [1:0] {
        REQ_SYNC    = 2'd0,
        REQ_STAMP   = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_ZERO     = 3'd1,
        ST_BACKWARD = 3'd2,
        ST_FROZEN   = 3'd3,
        ST_UNSYNCED = 3'd4,
        ST_FUTURE   = 3'd5,
        ST_STALE    = 3'd6
    } status_t;

    typedef struct packed {
        req_t               req_type;
        logic [1:0]         stream_id;
        logic [63:0]        stamp_us;
        logic signed [63:0] local_ns;
        logic [31:0]        query_age_us;
    } tfg_in_t;

    typedef struct packed {
        status_t     status;
        logic        is_current;
        logic [63:0] estimate_now_us;
    } tfg_out_t;

    typedef struct packed {
        req_t                    req;
        logic [STREAM_IDX_W-1:0] idx;
        logic [63:0]             stamp;
        logic [31:0]             qage;
        status_t                 sync_status;
    } tfg_tag_t;

    typedef struct packed {
        tfg_tag_t    tag;
        logic        est_ok;
        logic [63:0] remote;
        logic [62:0] diff;
    } tfg_est_t;

    typedef struct packed {
        tfg_tag_t    tag;
        logic [63:0] now;
    } tfg_now_t;

endpackage

// File: rtl/core/tfg_sync.sv
`timescale 1ns / 1ps

module tfg_sync #(
    parameter int NUM_STREAMS = tfg_pkg::NUM_STREAMS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tfg_pkg::tfg_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tfg_pkg::tfg_est_t out_stage
);
    import tfg_pkg::*;

    logic [63:0]        sync_remote_reg;
    logic [63:0]        sync_remote_next;
    logic signed [63:0] sync_local_reg;
    logic signed [63:0] sync_local_next;
    logic               valid_reg;
    tfg_est_t           stage_reg;
    tfg_est_t           stage_next;
    status_t            sync_status;
    logic               fire;
    logic [1:0]         id_red;
    logic signed [63:0] local_ns;
    logic signed [63:0] elapsed;
    logic               est_ok;

    assign in_ready  = !valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;
    assign local_ns  = in_data.local_ns;

    always_comb begin
        if (in_data.stamp_us == '0 || local_ns[63]) begin
            sync_status = ST_ZERO;
        end else if (!sync_local_reg[63] && local_ns < sync_local_reg) begin
            sync_status = ST_BACKWARD;
        end else if (sync_remote_reg != '0 && in_data.stamp_us == sync_remote_reg) begin
            sync_status = ST_FROZEN;
        end else if (sync_remote_reg != '0 && in_data.stamp_us < sync_remote_reg) begin
            sync_status = ST_BACKWARD;
        end else begin
            sync_status = ST_ACCEPTED;
        end
    end

    always_comb begin
        sync_remote_next = sync_remote_reg;
        sync_local_next  = sync_local_reg;
        if (fire) begin
            case (in_data.req_type)
                REQ_SYNC: begin
                    if (sync_status == ST_ACCEPTED) begin
                        sync_remote_next = in_data.stamp_us;
                        sync_local_next  = local_ns;
                    end
                end
                REQ_RESTART: begin
                    sync_remote_next = '0;
                    sync_local_next  = '1;
                end
                default: begin
                end
            endcase
        end
    end

    // stream index folded into range
    always_comb begin
        id_red = in_data.stream_id;
        for (int k = 0; k < 3; k++) begin
            if (int'(id_red) >= NUM_STREAMS) begin
                id_red = id_red - 2'(NUM_STREAMS);
            end
        end
    end

    // estimate is taken after this transaction's own update
    assign est_ok  = sync_remote_next != '0 && !sync_local_next[63]
                     && local_ns >= sync_local_next;
    assign elapsed = local_ns - sync_local_next;

    always_comb begin
        stage_next.tag.req         = in_data.req_type;
        stage_next.tag.idx         = STREAM_IDX_W'(id_red);
        stage_next.tag.stamp       = in_data.stamp_us;
        stage_next.tag.qage        = in_data.query_age_us;
        stage_next.tag.sync_status = (in_data.req_type == REQ_SYNC) ? sync_status
                                                                    : ST_ACCEPTED;
        stage_next.est_ok          = est_ok;
        stage_next.remote          = sync_remote_next;
        stage_next.diff            = est_ok ? elapsed[62:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_remote_reg <= '0;
            sync_local_reg  <= '1;
            valid_reg       <= 1'b0;
        end else begin
            sync_remote_reg <= sync_remote_next;
            sync_local_reg  <= sync_local_next;
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            stage_reg <= stage_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_sync_coherent: assert property (@(posedge aclk) disable iff (!aresetn)
        sync_remote_reg == '0 || !sync_local_reg[63])
        else $error("sync pair incoherent");

    a_sync_store: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_data.req_type == REQ_SYNC && sync_status == ST_ACCEPTED
        |=> sync_remote_reg == $past(in_data.stamp_us))
        else $error("accepted sync sample not stored");
`endif

endmodule

// File: rtl/core/tfg_div.sv
`timescale 1ns / 1ps

module tfg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tfg_pkg::tfg_est_t in_stage,
    output logic              out_valid,
    input  logic              out_ready,
    output tfg_pkg::tfg_now_t out_stage
);
    import tfg_pkg::*;

    typedef struct packed {
        tfg_tag_t    tag;
        logic        est_ok;
        logic [63:0] remote;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } prod_t;

    typedef struct packed {
        tfg_tag_t    tag;
        logic        est_ok;
        logic [63:0] remote;
        logic [64:0] mid;
        logic [31:0] p00_hi;
        logic [63:0] p11;
    } mid_t;

    typedef struct packed {
        tfg_tag_t       tag;
        logic           est_ok;
        logic [63:0]    remote;
        logic [Q_W-1:0] q;
    } quo_t;

    prod_t       prod_reg, prod_next;
    mid_t        mid_reg, mid_next;
    quo_t        quo_reg, quo_next;
    tfg_now_t    now_reg, now_next;
    logic        vp_reg, vm_reg, vq_reg, vn_reg;
    logic        en_p, en_m, en_q, en_n;
    logic [31:0] d0;
    logic [30:0] d1;
    logic [32:0] lo_sum;
    logic [63:0] hi_sum;

    assign en_n      = !vn_reg || out_ready;
    assign en_q      = !vq_reg || en_n;
    assign en_m      = !vm_reg || en_q;
    assign en_p      = !vp_reg || en_m;
    assign in_ready  = en_p;
    assign out_valid = vn_reg;
    assign out_stage = now_reg;

    // partial products of diff * RECIP_1000
    assign d0 = in_stage.diff[31:0];
    assign d1 = in_stage.diff[62:32];

    always_comb begin
        prod_next.tag    = in_stage.tag;
        prod_next.est_ok = in_stage.est_ok;
        prod_next.remote = in_stage.remote;
        prod_next.p00    = 64'(d0) * 64'(RECIP_1000[31:0]);
        prod_next.p01    = 64'(d0) * 64'(RECIP_1000[63:32]);
        prod_next.p10    = 64'(d1) * 64'(RECIP_1000[31:0]);
        prod_next.p11    = 64'(d1) * 64'(RECIP_1000[63:32]);
    end

    always_comb begin
        mid_next.tag    = prod_reg.tag;
        mid_next.est_ok = prod_reg.est_ok;
        mid_next.remote = prod_reg.remote;
        mid_next.mid    = 65'(prod_reg.p01) + 65'(prod_reg.p10);
        mid_next.p00_hi = prod_reg.p00[63:32];
        mid_next.p11    = prod_reg.p11;
    end

    assign lo_sum = 33'(mid_reg.p00_hi) + 33'(mid_reg.mid[31:0]);
    assign hi_sum = mid_reg.p11 + 64'(mid_reg.mid[64:32]) + 64'(lo_sum[32]);

    always_comb begin
        quo_next.tag    = mid_reg.tag;
        quo_next.est_ok = mid_reg.est_ok;
        quo_next.remote = mid_reg.remote;
        quo_next.q      = hi_sum[Q_LSB +: Q_W];
    end

    always_comb begin
        now_next.tag = quo_reg.tag;
        now_next.now = quo_reg.est_ok ? quo_reg.remote + 64'(quo_reg.q) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vm_reg <= 1'b0;
            vq_reg <= 1'b0;
            vn_reg <= 1'b0;
        end else begin
            if (en_p) begin
                vp_reg <= in_valid;
            end
            if (en_m) begin
                vm_reg <= vp_reg;
            end
            if (en_q) begin
                vq_reg <= vm_reg;
            end
            if (en_n) begin
                vn_reg <= vq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p) begin
            prod_reg <= prod_next;
        end
        if (en_m) begin
            mid_reg <= mid_next;
        end
        if (en_q) begin
            quo_reg <= quo_next;
        end
        if (en_n) begin
            now_reg <= now_next;
        end
    end

endmodule

// File: rtl/core/tfg_check.sv
`timescale 1ns / 1ps

module tfg_check #(
    parameter int NUM_STREAMS = tfg_pkg::NUM_STREAMS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tfg_pkg::tfg_now_t               in_stage,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tfg_pkg::tfg_out_t               m_data
);
    import tfg_pkg::*;

    localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    logic [31:0]      max_age_reg;
    logic [31:0]      max_future_reg;
    logic [63:0]      stream_last_reg [NUM_STREAMS];
    logic             out_valid_reg;
    tfg_out_t         out_data_reg;
    tfg_out_t         out_data_next;
    logic             fire;
    logic [IDX_W-1:0] idx;
    logic [63:0]      last;
    logic [63:0]      now;
    logic [63:0]      stamp;
    logic [31:0]      limit;
    logic [63:0]      fut_sum;
    logic             current;
    status_t          stamp_status;
    logic             write_en;
    logic             clear_all;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || m_ready;
    assign fire      = in_valid && in_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign idx   = in_stage.tag.idx[IDX_W-1:0];
    assign last  = stream_last_reg[idx];
    assign now   = in_stage.now;
    assign stamp = in_stage.tag.stamp;

    always_comb begin
        if (stamp == '0) begin
            stamp_status = ST_ZERO;
        end else if (now == '0) begin
            stamp_status = ST_UNSYNCED;
        end else if (last != '0 && stamp == last) begin
            stamp_status = ST_FROZEN;
        end else if (last != '0 && stamp < last) begin
            stamp_status = ST_BACKWARD;
        end else if (stamp > now && (stamp - now) > 64'(max_future_reg)) begin
            stamp_status = ST_FUTURE;
        end else if (now > stamp && (now - stamp) > 64'(max_age_reg)) begin
            stamp_status = ST_STALE;
        end else begin
            stamp_status = ST_ACCEPTED;
        end
    end

    assign limit   = (in_stage.tag.qage == '0) ? max_age_reg : in_stage.tag.qage;
    assign fut_sum = now + 64'(max_future_reg);
    assign current = now != '0 && last != '0 && last <= fut_sum
                     && (last >= now || (now - last) <= 64'(limit));

    always_comb begin
        out_data_next.estimate_now_us = now;
        out_data_next.is_current      = 1'b0;
        case (in_stage.tag.req)
            REQ_SYNC: begin
                out_data_next.status = in_stage.tag.sync_status;
            end
            REQ_STAMP: begin
                out_data_next.status = stamp_status;
            end
            REQ_QUERY: begin
                out_data_next.status     = ST_ACCEPTED;
                out_data_next.is_current = current;
            end
            default: begin
                out_data_next.status = ST_ACCEPTED;
            end
        endcase
    end

    assign write_en  = fire && in_stage.tag.req == REQ_STAMP && stamp_status == ST_ACCEPTED;
    assign clear_all = fire && in_stage.tag.req == REQ_RESTART;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg    <= '0;
            max_future_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_AGE: begin
                    max_age_reg <= cfg_data[31:0];
                end
                REG_MAX_FUTURE: begin
                    max_future_reg <= cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            for (int i = 0; i < NUM_STREAMS; i++) begin
                stream_last_reg[i] <= '0;
            end
        end else if (write_en) begin
            stream_last_reg[idx] <= stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_all |=> stream_last_reg[0] == '0)
        else $error("restart left a stream entry set");

    a_store_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        write_en |=> stream_last_reg[$past(idx)] != '0)
        else $error("zero stamp stored");

    a_unsynced_estimate: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.status == ST_UNSYNCED
        |-> out_data_reg.estimate_now_us == '0)
        else $error("unsynced stamp with nonzero estimate");
`endif

endmodule

// File: rtl/core/timestamp_freshness_gate.sv
`timescale 1ns / 1ps

// Timestamp freshness gate. Takes one transaction per clock on s_ unless m_ready back-pressure
// stalls the pipeline, and returns one result per transaction on m_, in order. Sync samples
// update the sync pair in the first stage after the input register; the estimate (synced time
// plus elapsed ns / 1000) goes through a four-stage reciprocal multiply built from 32x32 partial
// products; stream checks, queries and the per-stream last values live in the final stage ahead
// of the output register. Back-pressure on m_ready stalls the pipeline but empty stages still
// fill. No clearing pass after reset. Write cfg_ only while no transaction is in flight.
module timestamp_freshness_gate #(
    parameter int NUM_STREAMS = tfg_pkg::NUM_STREAMS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tfg_pkg::tfg_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tfg_pkg::tfg_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tfg_pkg::*;

    logic     in_valid_reg;
    tfg_in_t  in_data_reg;
    logic     sync_in_ready;
    logic     est_valid;
    logic     est_ready;
    tfg_est_t est_stage;
    logic     now_valid;
    logic     now_ready;
    tfg_now_t now_stage;

    assign s_ready = !in_valid_reg || sync_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    tfg_sync #(
        .NUM_STREAMS(NUM_STREAMS)
    ) u_sync (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (sync_in_ready),
        .in_data   (in_data_reg),
        .out_valid (est_valid),
        .out_ready (est_ready),
        .out_stage (est_stage)
    );

    tfg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (est_valid),
        .in_ready  (est_ready),
        .in_stage  (est_stage),
        .out_valid (now_valid),
        .out_ready (now_ready),
        .out_stage (now_stage)
    );

    tfg_check #(
        .NUM_STREAMS(NUM_STREAMS)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (now_valid),
        .in_ready  (now_ready),
        .in_stage  (now_stage),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
